// ===== design/apvm_pkg.sv =====
// shared constants, codes and step table for the pitched adpcm voice mixer
package apvm_pkg;

  localparam int SAMPLE_BYTES_DEF = 65536;

  // fixed field widths
  localparam int BYTE_ADDR_W = 16;
  localparam int RD_ADDR_W   = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // request codes
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INV_PITCH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_CNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOLUME    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOOP_EN   = 3'd4;

  // register reset values
  localparam logic [15:0] INV_PITCH_RST = 16'd256;
  localparam logic [8:0]  VOLUME_RST    = 9'd128;

  // quantizer step limits
  localparam logic [14:0] STEP_MIN = 15'd127;
  localparam logic [14:0] STEP_MAX = 15'd24576;

  // step rescale factor, q6, by nibble magnitude
  function automatic logic [7:0] step_scale(input logic [2:0] mag);
    logic [7:0] f;
    case (mag)
      3'd4:    f = 8'd77;
      3'd5:    f = 8'd102;
      3'd6:    f = 8'd128;
      3'd7:    f = 8'd153;
      default: f = 8'd57;
    endcase
    return f;
  endfunction

endpackage

// ===== design/adpcm_pitched_voice_mixer_unit.sv =====
// top level of the pitched single-voice adpcm mixer
//
// one voice plays 4-bit adpcm (high nibble of each byte first) out of an
// internal byte memory that is filled by load requests. a request is taken
// when start is high and busy is low. load and restart requests leave busy
// low and give no result. a mix tick gives exactly one result, shown on
// out_mix_out / out_voice_active for one cycle with out_valid high; the
// receiver must take it then. a tick on a stopped voice returns its result
// the cycle after it is taken. a tick on a playing voice keeps busy high while
// it decodes; each nibble takes a memory read, delta and step products and a
// history update. when a looping voice wraps on a tick that was not played,
// the tick sequence runs once more from the start. the decode rate is set by
// the registered read of the sample memory and the two-stage nibble update.
// the user must write registers over the cfg port only while the block is
// idle; the block does not enforce this, and cfg_ready is always high.
module adpcm_pitched_voice_mixer_unit import apvm_pkg::*; #(
  parameter int SAMPLE_BYTES = SAMPLE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_op,
  input  logic [BYTE_ADDR_W-1:0] in_byte_address,
  input  logic [7:0]             in_byte_value,
  input  logic signed [15:0]     in_mix_in,
  output logic                   out_valid,
  output logic signed [15:0]     out_mix_out,
  output logic                   out_voice_active,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADV,
    S_MUL,
    S_CHECK,
    S_NIB,
    S_UPD,
    S_SCALE,
    S_MIX,
    S_END
  } state_t;

  state_t state_r;

  // configuration registers
  logic [15:0] inv_pitch_r;
  logic [17:0] sample_count_r;
  logic [23:0] pitched_len_r;
  logic [8:0]  volume_r;
  logic        loop_en_r;

  // voice and decoder state
  logic signed [15:0] hist_r;
  logic signed [15:0] dec_r;
  logic [14:0]        qstep_r;
  logic               low_next_r;
  logic [17:0]        nib_pos_r;
  logic [23:0]        tick_r;
  logic [RD_ADDR_W-1:0] rd_addr_r;
  logic [7:0]         held_r;
  logic               playing_r;

  // per-tick working registers
  logic [31:0]        target_r;
  logic [15:0]        delta_r;
  logic               delta_neg_r;
  logic [14:0]        step_new_r;
  logic signed [25:0] prod_r;
  logic signed [15:0] mix_r;
  logic               played_r;
  logic               second_r;
  logic               single_r;

  // result registers
  logic               out_valid_r;
  logic signed [15:0] out_mix_r;
  logic               out_active_r;

  // memory port
  logic       ram_wr_en;
  logic       ram_rd_en;
  logic [7:0] ram_rd_data;

  // datapath
  logic               accept;
  logic               can_decode;
  logic               below_target;
  logic               tick_more;
  logic               vol_zero;
  logic [7:0]         cur_byte;
  logic [3:0]         cur_nib;
  logic [2:0]         mag;
  logic [18:0]        d_prod;
  logic [22:0]        ns_prod;
  logic [16:0]        ns_raw;
  logic [14:0]        ns_clamped;
  logic signed [17:0] upd_sum;
  logic signed [15:0] upd_sat;
  logic [39:0]        tgt_prod;
  logic signed [17:0] scaled;
  logic signed [18:0] mix_sum;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign cfg_ready = 1'b1;

  assign out_valid        = out_valid_r;
  assign out_mix_out      = out_mix_r;
  assign out_voice_active = out_active_r;

  // position checks
  assign can_decode   = ({1'b0, nib_pos_r} + 19'd1) < {1'b0, sample_count_r};
  assign below_target = {14'd0, nib_pos_r} < target_r;
  assign tick_more    = ({1'b0, tick_r} + 25'd1) < {1'b0, pitched_len_r};
  assign vol_zero     = volume_r == 9'd0;

  assign ram_wr_en = accept && in_op == OP_LOAD;
  assign ram_rd_en = (state_r == S_ADV && vol_zero && can_decode) ||
                     (state_r == S_CHECK && can_decode && below_target);

  apvm_sample_ram #(
    .SAMPLE_BYTES(SAMPLE_BYTES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (in_byte_address),
    .wr_data (in_byte_value),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_addr_r),
    .rd_data (ram_rd_data)
  );

  // nibble select: a fresh byte from memory or the low half of the held one
  assign cur_byte = low_next_r ? held_r : ram_rd_data;
  assign cur_nib  = low_next_r ? cur_byte[3:0] : cur_byte[7:4];
  assign mag      = cur_nib[2:0];

  // delta = (2*mag+1) * step / 8, new step = scale * step / 64
  assign d_prod  = 19'({mag, 1'b1}) * 19'(qstep_r);
  assign ns_prod = 23'(step_scale(mag)) * 23'(qstep_r);
  assign ns_raw  = ns_prod[22:6];

  always_comb begin
    if (ns_raw < 17'(STEP_MIN)) begin
      ns_clamped = STEP_MIN;
    end else if (ns_raw > 17'(STEP_MAX)) begin
      ns_clamped = STEP_MAX;
    end else begin
      ns_clamped = ns_raw[14:0];
    end
  end

  // history update with saturation
  always_comb begin
    if (delta_neg_r) begin
      upd_sum = $signed({{2{hist_r[15]}}, hist_r}) - $signed({2'b00, delta_r});
    end else begin
      upd_sum = $signed({{2{hist_r[15]}}, hist_r}) + $signed({2'b00, delta_r});
    end
  end
  assign upd_sat = sat16($signed({upd_sum[17], upd_sum}));

  // pitched target: tick * inverse pitch, q8
  assign tgt_prod = 40'(tick_r) * 40'(inv_pitch_r);

  // volume scale is a floor shift of the product, then add and saturate
  assign scaled  = $signed(prod_r[25:8]);
  assign mix_sum = $signed({{3{mix_r[15]}}, mix_r}) + $signed({scaled[17], scaled});

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_pitch_r    <= INV_PITCH_RST;
      sample_count_r <= '0;
      pitched_len_r  <= '0;
      volume_r       <= VOLUME_RST;
      loop_en_r      <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_INV_PITCH:  inv_pitch_r    <= cfg_data[15:0];
        CFG_SAMPLE_CNT: sample_count_r <= cfg_data[17:0];
        CFG_PITCH_LEN:  pitched_len_r  <= cfg_data[23:0];
        CFG_VOLUME:     volume_r       <= cfg_data[8:0];
        CFG_LOOP_EN:    loop_en_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // control sequencer with voice state and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      playing_r   <= 1'b0;
      hist_r      <= '0;
      dec_r       <= '0;
      qstep_r     <= STEP_MIN;
      low_next_r  <= 1'b0;
      nib_pos_r   <= '0;
      tick_r      <= '0;
      rd_addr_r   <= '0;
      held_r      <= '0;
      played_r    <= 1'b0;
      second_r    <= 1'b0;
      single_r    <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_op == OP_RESTART) begin
              hist_r     <= '0;
              dec_r      <= '0;
              qstep_r    <= STEP_MIN;
              low_next_r <= 1'b0;
              nib_pos_r  <= '0;
              tick_r     <= '0;
              rd_addr_r  <= '0;
              held_r     <= '0;
              playing_r  <= 1'b1;
            end else if (in_op == OP_TICK) begin
              mix_r    <= in_mix_in;
              played_r <= tick_more;
              second_r <= 1'b0;
              if (!playing_r) begin
                // stopped voice passes the mix sample through
                out_valid_r  <= 1'b1;
                out_mix_r    <= in_mix_in;
                out_active_r <= 1'b0;
              end else if (tick_more) begin
                state_r <= S_ADV;
              end else begin
                state_r <= S_END;
              end
            end
          end
        end
        S_ADV: begin
          tick_r <= tick_r + 24'd1;
          if (vol_zero) begin
            // silent path: at most one nibble, mix unchanged
            single_r <= 1'b1;
            state_r  <= can_decode ? S_NIB : S_END;
          end else begin
            single_r <= 1'b0;
            state_r  <= S_MUL;
          end
        end
        S_MUL: begin
          target_r <= tgt_prod[39:8];
          state_r  <= S_CHECK;
        end
        S_CHECK: begin
          state_r <= (can_decode && below_target) ? S_NIB : S_SCALE;
        end
        S_NIB: begin
          if (!low_next_r) begin
            held_r    <= ram_rd_data;
            rd_addr_r <= rd_addr_r + RD_ADDR_W'(1);
          end
          low_next_r  <= !low_next_r;
          nib_pos_r   <= nib_pos_r + 18'd1;
          delta_r     <= d_prod[18:3];
          delta_neg_r <= cur_nib[3];
          step_new_r  <= ns_clamped;
          state_r     <= S_UPD;
        end
        S_UPD: begin
          hist_r  <= upd_sat;
          dec_r   <= upd_sat;
          qstep_r <= step_new_r;
          state_r <= single_r ? S_END : S_CHECK;
        end
        S_SCALE: begin
          prod_r  <= 26'(dec_r) * 26'($signed({1'b0, volume_r}));
          state_r <= S_MIX;
        end
        S_MIX: begin
          mix_r   <= sat16(mix_sum);
          state_r <= S_END;
        end
        S_END: begin
          if (second_r || tick_more) begin
            out_valid_r  <= 1'b1;
            out_mix_r    <= mix_r;
            out_active_r <= playing_r;
            state_r      <= S_IDLE;
          end else if (loop_en_r) begin
            // end of pass: restart and replay an unplayed tick
            hist_r     <= '0;
            dec_r      <= '0;
            qstep_r    <= STEP_MIN;
            low_next_r <= 1'b0;
            nib_pos_r  <= '0;
            tick_r     <= '0;
            rd_addr_r  <= '0;
            held_r     <= '0;
            if (!played_r) begin
              second_r <= 1'b1;
              state_r  <= S_ADV;
            end else begin
              out_valid_r  <= 1'b1;
              out_mix_r    <= mix_r;
              out_active_r <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            playing_r    <= 1'b0;
            out_valid_r  <= 1'b1;
            out_mix_r    <= mix_r;
            out_active_r <= 1'b0;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // results only leave on the way back to idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> state_r == S_IDLE)
    else $error("result strobe outside idle");

  // step size stays inside its clamp range
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    qstep_r >= STEP_MIN && qstep_r <= STEP_MAX)
    else $error("quantizer step out of range");

  // nibble phase tracks the nibble count
  a_nib_phase: assert property (@(posedge clk) disable iff (!rst_n)
    low_next_r == nib_pos_r[0])
    else $error("nibble phase out of step with position");

  // byte pointer follows the nibble count
  a_rd_addr: assert property (@(posedge clk) disable iff (!rst_n)
    rd_addr_r == RD_ADDR_W'((19'(nib_pos_r) + 19'd1) >> 1))
    else $error("read address out of step with position");

  // a decode read is only issued while the voice plays
  a_read_playing: assert property (@(posedge clk) disable iff (!rst_n)
    ram_rd_en |-> playing_r && busy)
    else $error("memory read while voice stopped");

endmodule

// ===== design/apvm_sample_ram.sv =====
// byte-wide sample memory with range-checked write and registered read
module apvm_sample_ram import apvm_pkg::*; #(
  parameter int SAMPLE_BYTES = SAMPLE_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [BYTE_ADDR_W-1:0] wr_addr,
  input  logic [7:0]             wr_data,
  input  logic                   rd_en,
  input  logic [RD_ADDR_W-1:0]   rd_addr,
  output logic [7:0]             rd_data
);

  localparam int AW = $clog2(SAMPLE_BYTES);
  localparam int XW = AW + RD_ADDR_W;

  logic [7:0]    mem [SAMPLE_BYTES];
  logic [XW-1:0] wr_ext;
  logic [XW-1:0] rd_ext;
  logic          wr_ok;
  logic          rd_ok;
  logic          rd_ok_r;
  logic [7:0]    rd_data_r;

  assign wr_ext = XW'(wr_addr);
  assign rd_ext = XW'(rd_addr);
  assign wr_ok  = 32'(wr_addr) < 32'(SAMPLE_BYTES);
  assign rd_ok  = 32'(rd_addr) < 32'(SAMPLE_BYTES);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[wr_ext[AW-1:0]] <= wr_data;
    end
  end

  // reads past the end return zero
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ok_r <= rd_ok;
      if (rd_ok) begin
        rd_data_r <= mem[rd_ext[AW-1:0]];
      end
    end
  end

  assign rd_data = rd_ok_r ? rd_data_r : 8'd0;

endmodule
